### rtl/spinor_pkg.sv
package spinor_pkg;

    // request / reply codes on the mode field
    localparam logic [1:0] MODE_ERASE   = 2'd0;
    localparam logic [1:0] MODE_PROGRAM = 2'd1;
    localparam logic [1:0] MODE_STATUS  = 2'd2;

    // completion and rejection codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_REJECT  = 2'd2;

    // flash command bytes
    localparam logic [7:0] OP_UNLOCK = 8'h50;
    localparam logic [7:0] OP_WRSR   = 8'h01;
    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_RDSR   = 8'h05;
    localparam logic [7:0] OP_PP     = 8'h02;
    localparam logic [7:0] OP_SE     = 8'h20;
    localparam logic [7:0] SR_CLEAR  = 8'h00;
    localparam logic [7:0] DUMMY     = 8'h00;

    localparam logic [23:0] POLL_LIMIT_RESET = 24'd10000000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_UNLOCK,
        PH_WAIT_WREN,
        PH_WAIT_CMD
    } phase_t;

    // kind of result burst caused by one accepted item
    typedef enum logic [2:0] {
        BU_REJECT,
        BU_ERASE_START,
        BU_WREN,
        BU_POLL,
        BU_TIMEOUT,
        BU_PROG_CMD,
        BU_ERASE_CMD,
        BU_DONE
    } burst_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       end_of_frame;
        logic       reply_expected;
        logic       op_done;
        logic [1:0] error_code;
        logic       last;
    } item_t;

    // number of command bytes ahead of the trailing status poll
    function automatic logic [2:0] head_len(input burst_t kind);
        logic [2:0] len;
        case (kind)
            BU_ERASE_START: len = 3'd3;
            BU_WREN:        len = 3'd1;
            BU_PROG_CMD:    len = 3'd5;
            BU_ERASE_CMD:   len = 3'd4;
            default:        len = 3'd0;
        endcase
        return len;
    endfunction

    // result item at position idx of a burst
    function automatic item_t burst_item(input burst_t kind, input logic [2:0] idx,
                                         input logic [23:0] addr, input logic [7:0] data);
        item_t      it;
        logic [2:0] head;
        logic [7:0] addr_byte;
        it   = '0;
        head = head_len(kind);
        case (idx)
            3'd1:    addr_byte = addr[23:16];
            3'd2:    addr_byte = addr[15:8];
            default: addr_byte = addr[7:0];
        endcase
        case (kind)
            BU_REJECT: begin
                it.error_code = ERR_REJECT;
                it.last       = 1'b1;
            end
            BU_TIMEOUT: begin
                it.op_done    = 1'b1;
                it.error_code = ERR_TIMEOUT;
                it.last       = 1'b1;
            end
            BU_DONE: begin
                it.op_done    = 1'b1;
                it.error_code = ERR_OK;
                it.last       = 1'b1;
            end
            default: begin
                if (idx == head) begin
                    it.spi_byte = OP_RDSR;
                end else if (idx > head) begin
                    it.spi_byte       = DUMMY;
                    it.end_of_frame   = 1'b1;
                    it.reply_expected = 1'b1;
                    it.last           = 1'b1;
                end else begin
                    case (kind)
                        BU_ERASE_START: begin
                            case (idx)
                                3'd0: begin
                                    it.spi_byte     = OP_UNLOCK;
                                    it.end_of_frame = 1'b1;
                                end
                                3'd1:    it.spi_byte = OP_WRSR;
                                default: begin
                                    it.spi_byte     = SR_CLEAR;
                                    it.end_of_frame = 1'b1;
                                end
                            endcase
                        end
                        BU_WREN: begin
                            it.spi_byte     = OP_WREN;
                            it.end_of_frame = 1'b1;
                        end
                        BU_PROG_CMD: begin
                            if (idx == 3'd0) begin
                                it.spi_byte = OP_PP;
                            end else if (idx == 3'd4) begin
                                it.spi_byte     = data;
                                it.end_of_frame = 1'b1;
                            end else begin
                                it.spi_byte = addr_byte;
                            end
                        end
                        default: begin
                            if (idx == 3'd0) begin
                                it.spi_byte = OP_SE;
                            end else begin
                                it.spi_byte     = addr_byte;
                                it.end_of_frame = (idx == 3'd3);
                            end
                        end
                    endcase
                end
            end
        endcase
        return it;
    endfunction

endpackage

### rtl/spi_nor_erase_program_sequencer_top.sv
// Erase/program sequencer for a serial NOR flash. Each accepted item (erase request,
// program request or status reply) is decoded on acceptance into a burst of 1 to 7 result
// items, which leave on the m_ side one per cycle while m_ready is high, from the burst
// register. A rejection or completion gives 1 result, a busy re-poll 2 and the program
// command the most, 7; no new item is accepted until the last result of the previous one
// is taken, and the next is accepted in that same cycle. poll_limit is written
// through poll_limit_wr_en / poll_limit_wr_data and takes effect at the next status reply.
module spi_nor_erase_program_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        poll_limit_wr_en,
    input  logic [23:0] poll_limit_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [23:0] s_flash_address,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_reply_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_spi_byte,
    output logic        m_end_of_frame,
    output logic        m_reply_expected,
    output logic        m_op_done,
    output logic [1:0]  m_error_code,
    output logic        m_last
);

    spinor_pkg::phase_t phase_reg, phase_next;
    spinor_pkg::burst_t kind_reg, kind_sel;
    logic               op_is_program_reg;
    logic [23:0]        held_address_reg;
    logic [7:0]         held_data_reg;
    logic [23:0]        busy_polls_reg, busy_polls_next;
    logic [23:0]        poll_limit_reg;
    logic               valid_reg;
    logic [2:0]         idx_reg;
    spinor_pkg::item_t  item;
    logic               in_fire, out_fire;

    // current result item from the burst register
    assign item             = spinor_pkg::burst_item(kind_reg, idx_reg, held_address_reg,
                                                     held_data_reg);
    assign m_valid          = valid_reg;
    assign m_spi_byte       = item.spi_byte;
    assign m_end_of_frame   = item.end_of_frame;
    assign m_reply_expected = item.reply_expected;
    assign m_op_done        = item.op_done;
    assign m_error_code     = item.error_code;
    assign m_last           = item.last;

    assign out_fire = valid_reg & m_ready;
    assign s_ready  = ~valid_reg | (m_ready & item.last);
    assign in_fire  = s_valid & s_ready;

    // burst selection from the incoming item and the phase
    always_comb begin
        kind_sel = spinor_pkg::BU_REJECT;
        if (s_mode == spinor_pkg::MODE_ERASE && phase_reg == spinor_pkg::PH_IDLE) begin
            kind_sel = spinor_pkg::BU_ERASE_START;
        end else if (s_mode == spinor_pkg::MODE_PROGRAM
                     && phase_reg == spinor_pkg::PH_IDLE) begin
            kind_sel = spinor_pkg::BU_WREN;
        end else if (s_mode == spinor_pkg::MODE_STATUS
                     && phase_reg != spinor_pkg::PH_IDLE) begin
            if (s_reply_byte[0]) begin
                kind_sel = (busy_polls_reg >= poll_limit_reg) ? spinor_pkg::BU_TIMEOUT
                                                               : spinor_pkg::BU_POLL;
            end else if (phase_reg == spinor_pkg::PH_WAIT_UNLOCK) begin
                kind_sel = spinor_pkg::BU_WREN;
            end else if (phase_reg == spinor_pkg::PH_WAIT_WREN) begin
                kind_sel = op_is_program_reg ? spinor_pkg::BU_PROG_CMD
                                             : spinor_pkg::BU_ERASE_CMD;
            end else begin
                kind_sel = spinor_pkg::BU_DONE;
            end
        end
    end

    // next phase
    always_comb begin
        case (kind_sel)
            spinor_pkg::BU_ERASE_START: phase_next = spinor_pkg::PH_WAIT_UNLOCK;
            spinor_pkg::BU_WREN:        phase_next = spinor_pkg::PH_WAIT_WREN;
            spinor_pkg::BU_PROG_CMD:    phase_next = spinor_pkg::PH_WAIT_CMD;
            spinor_pkg::BU_ERASE_CMD:   phase_next = spinor_pkg::PH_WAIT_CMD;
            spinor_pkg::BU_TIMEOUT:     phase_next = spinor_pkg::PH_IDLE;
            spinor_pkg::BU_DONE:        phase_next = spinor_pkg::PH_IDLE;
            default:                    phase_next = phase_reg;
        endcase
    end

    // busy reply counter, cleared whenever a new wait begins or the operation ends
    always_comb begin
        case (kind_sel)
            spinor_pkg::BU_POLL:   busy_polls_next = busy_polls_reg + 24'd1;
            spinor_pkg::BU_REJECT: busy_polls_next = busy_polls_reg;
            default:               busy_polls_next = '0;
        endcase
    end

    // operation state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= spinor_pkg::PH_IDLE;
            op_is_program_reg <= 1'b0;
            held_address_reg  <= '0;
            held_data_reg     <= '0;
            busy_polls_reg    <= '0;
            poll_limit_reg    <= spinor_pkg::POLL_LIMIT_RESET;
        end else begin
            if (poll_limit_wr_en) begin
                poll_limit_reg <= poll_limit_wr_data;
            end
            if (in_fire) begin
                phase_reg      <= phase_next;
                busy_polls_reg <= busy_polls_next;
                if (kind_sel == spinor_pkg::BU_ERASE_START) begin
                    op_is_program_reg <= 1'b0;
                    held_address_reg  <= s_flash_address;
                end
                if (kind_sel == spinor_pkg::BU_WREN && phase_reg == spinor_pkg::PH_IDLE) begin
                    op_is_program_reg <= 1'b1;
                    held_address_reg  <= s_flash_address;
                    held_data_reg     <= s_data_byte;
                end
            end
        end
    end

    // burst register and result index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            kind_reg  <= spinor_pkg::BU_REJECT;
            idx_reg   <= '0;
        end else begin
            if (in_fire) begin
                valid_reg <= 1'b1;
                kind_reg  <= kind_sel;
                idx_reg   <= '0;
            end else if (out_fire) begin
                if (item.last) begin
                    valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    // checks
    a_idle_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == spinor_pkg::PH_IDLE |-> busy_polls_reg == '0)
        else $error("busy counter not clear in idle");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_op_done || m_error_code != spinor_pkg::ERR_OK) |-> m_last)
        else $error("completion or rejection item not last");

    a_poll_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reply_expected |-> m_last && m_end_of_frame)
        else $error("status dummy byte does not close the burst");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && !m_last |=> m_valid && idx_reg == $past(idx_reg) + 3'd1)
        else $error("burst index did not advance");

    a_erase_starts_unlock: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_mode == spinor_pkg::MODE_ERASE && phase_reg == spinor_pkg::PH_IDLE
        |=> m_valid && m_spi_byte == spinor_pkg::OP_UNLOCK && m_end_of_frame)
        else $error("erase did not start with unlock");

endmodule
